### hw/rtl/dlipd_pkg.sv
// Shared types, constants and control-word layout for the dual-loop duty controller.
package dlipd_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int GAIN_W         = 24;
  localparam int IDX_W          = 4;
  localparam int CFG_W          = 24;
  localparam int ERR_W          = SAMPLE_W + 1;
  localparam int DLT_W          = SAMPLE_W + 2;
  localparam int DDL_W          = SAMPLE_W + 3;
  localparam int PROD_W         = GAIN_W + 1 + DDL_W;
  localparam int ACC_W          = 48;
  localparam int DUTY_FRAC_BITS = 40;
  localparam int LO_W           = DUTY_FRAC_BITS - GAIN_W;
  localparam int PERIOD_COUNTS  = 18432;
  localparam int PULSE_W        = 16;
  localparam int STEP_W         = 4;

  typedef logic        [SAMPLE_W-1:0]       sample_t;
  typedef logic        [GAIN_W-1:0]         gain_t;
  typedef logic signed [ERR_W-1:0]          err_t;
  typedef logic signed [DLT_W-1:0]          dlt_t;
  typedef logic signed [DDL_W-1:0]          ddl_t;
  typedef logic signed [PROD_W-1:0]         prod_t;
  typedef logic signed [ACC_W-1:0]          acc_t;
  typedef logic        [DUTY_FRAC_BITS-1:0] duty_t;
  typedef logic        [PULSE_W-1:0]        pulse_t;
  typedef logic        [STEP_W-1:0]         step_t;

  localparam duty_t DUTY_HIGH = duty_t'((64'd92 << DUTY_FRAC_BITS) / 64'd100);
  localparam duty_t DUTY_LOW  = duty_t'((64'd2 << DUTY_FRAC_BITS) / 64'd100);
  localparam acc_t  DUTY_ONE  = acc_t'(64'd1 << DUTY_FRAC_BITS);
  localparam ddl_t  PERIOD_OP = ddl_t'(PERIOD_COUNTS);

  localparam gain_t KP_RESET = gain_t'(1832519);
  localparam gain_t KI_RESET = gain_t'(366504);
  localparam gain_t KD_RESET = gain_t'(0);

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_V = 4'd0,
    REG_TARGET_I = 4'd1,
    REG_VOLT_KP  = 4'd2,
    REG_VOLT_KI  = 4'd3,
    REG_VOLT_KD  = 4'd4,
    REG_CURR_KP  = 4'd5,
    REG_CURR_KI  = 4'd6,
    REG_CURR_KD  = 4'd7
  } reg_idx_t;

  typedef struct packed {
    sample_t volt_setpoint;
    sample_t curr_setpoint;
    gain_t   volt_prop_gain;
    gain_t   volt_integ_gain;
    gain_t   volt_deriv_gain;
    gain_t   curr_prop_gain;
    gain_t   curr_integ_gain;
    gain_t   curr_deriv_gain;
  } cfg_t;

  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_DIFF = 4'd1;
  localparam step_t STEP_MULP = 4'd2;
  localparam step_t STEP_MULI = 4'd3;
  localparam step_t STEP_MULD = 4'd4;
  localparam step_t STEP_FIN  = 4'd5;
  localparam step_t STEP_SEL  = 4'd6;
  localparam step_t STEP_MULH = 4'd7;
  localparam step_t STEP_MULL = 4'd8;
  localparam step_t STEP_OUT  = 4'd9;

  typedef enum logic [2:0] {
    MA_KP,
    MA_KI,
    MA_KD,
    MA_HI,
    MA_LO
  } mul_a_t;

  typedef enum logic [1:0] {
    MB_ERR,
    MB_DLT,
    MB_DDL,
    MB_PER
  } mul_b_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_STATE,
    ACC_ADD,
    ACC_PROD
  } acc_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_LOOP,
    JMP_WAIT_OUT,
    JMP_GOTO
  } jmp_t;

  typedef struct packed {
    mul_a_t  a_sel;
    mul_b_t  b_sel;
    acc_op_t acc_op;
    logic    diff_en;
    logic    wb_en;
    logic    sel_en;
    jmp_t    jmp;
    step_t   target;
  } uword_t;

  localparam uword_t UW_NOP = '{
    a_sel:   MA_KP,
    b_sel:   MB_ERR,
    acc_op:  ACC_HOLD,
    diff_en: 1'b0,
    wb_en:   1'b0,
    sel_en:  1'b0,
    jmp:     JMP_NEXT,
    target:  STEP_IDLE
  };

  typedef struct packed {
    uword_t uw;
    logic   loop_sel;
    logic   take;
    logic   load_out;
    logic   in_ready;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } status_t;

endpackage

### hw/rtl/dlipd_sample_if.sv
// Sample channel: one voltage and one current sample per item.
interface dlipd_sample_if;
  logic                 valid;
  logic                 ready;
  dlipd_pkg::sample_t   vout_sample;
  dlipd_pkg::sample_t   iout_sample;

  modport source (output valid, output vout_sample, output iout_sample, input ready);
  modport sink   (input valid, input vout_sample, input iout_sample, output ready);
endinterface

### hw/rtl/dlipd_result_if.sv
// Result channel: compare value, half compare value and current-limit flag.
interface dlipd_result_if;
  logic                          valid;
  logic                          ready;
  dlipd_pkg::pulse_t             compare_value;
  logic [dlipd_pkg::PULSE_W-2:0] half_pulse;
  logic                          current_limiting;

  modport source (output valid, output compare_value, output half_pulse,
                  output current_limiting, input ready);
  modport sink   (input valid, input compare_value, input half_pulse,
                  input current_limiting, output ready);
endinterface

### hw/rtl/dlipd_cfg_if.sv
// Configuration write channel: register index and write data.
interface dlipd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dlipd_pkg::IDX_W-1:0] index;
  logic [dlipd_pkg::CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/dlipd_cfg_regs.sv
// Setpoint and gain register file.
module dlipd_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  dlipd_cfg_if.sink       cfg,
  output dlipd_pkg::cfg_t regs
);

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.volt_setpoint   <= '0;
      regs.curr_setpoint   <= '0;
      regs.volt_prop_gain  <= dlipd_pkg::KP_RESET;
      regs.volt_integ_gain <= dlipd_pkg::KI_RESET;
      regs.volt_deriv_gain <= dlipd_pkg::KD_RESET;
      regs.curr_prop_gain  <= dlipd_pkg::KP_RESET;
      regs.curr_integ_gain <= dlipd_pkg::KI_RESET;
      regs.curr_deriv_gain <= dlipd_pkg::KD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        dlipd_pkg::REG_TARGET_V: regs.volt_setpoint   <= dlipd_pkg::sample_t'(cfg.data);
        dlipd_pkg::REG_TARGET_I: regs.curr_setpoint   <= dlipd_pkg::sample_t'(cfg.data);
        dlipd_pkg::REG_VOLT_KP:  regs.volt_prop_gain  <= dlipd_pkg::gain_t'(cfg.data);
        dlipd_pkg::REG_VOLT_KI:  regs.volt_integ_gain <= dlipd_pkg::gain_t'(cfg.data);
        dlipd_pkg::REG_VOLT_KD:  regs.volt_deriv_gain <= dlipd_pkg::gain_t'(cfg.data);
        dlipd_pkg::REG_CURR_KP:  regs.curr_prop_gain  <= dlipd_pkg::gain_t'(cfg.data);
        dlipd_pkg::REG_CURR_KI:  regs.curr_integ_gain <= dlipd_pkg::gain_t'(cfg.data);
        dlipd_pkg::REG_CURR_KD:  regs.curr_deriv_gain <= dlipd_pkg::gain_t'(cfg.data);
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/dlipd_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module dlipd_seq (
  input  logic               clk,
  input  logic               rst,
  input  dlipd_pkg::status_t status,
  output dlipd_pkg::ctrl_t   ctrl
);

  dlipd_pkg::step_t  step;
  dlipd_pkg::step_t  step_next;
  logic              loop_sel;
  logic              loop_sel_next;
  logic              take;
  logic              load_out;
  dlipd_pkg::uword_t uw;

  function automatic dlipd_pkg::uword_t ucode(input dlipd_pkg::step_t s);
    dlipd_pkg::uword_t w;
    w = dlipd_pkg::UW_NOP;
    unique case (s)
      dlipd_pkg::STEP_IDLE: begin
        w.jmp = dlipd_pkg::JMP_WAIT_IN;
      end
      dlipd_pkg::STEP_DIFF: begin
        w.diff_en = 1'b1;
        w.acc_op  = dlipd_pkg::ACC_STATE;
      end
      dlipd_pkg::STEP_MULP: begin
        w.a_sel = dlipd_pkg::MA_KP;
        w.b_sel = dlipd_pkg::MB_DLT;
      end
      dlipd_pkg::STEP_MULI: begin
        w.a_sel  = dlipd_pkg::MA_KI;
        w.b_sel  = dlipd_pkg::MB_ERR;
        w.acc_op = dlipd_pkg::ACC_ADD;
      end
      dlipd_pkg::STEP_MULD: begin
        w.a_sel  = dlipd_pkg::MA_KD;
        w.b_sel  = dlipd_pkg::MB_DDL;
        w.acc_op = dlipd_pkg::ACC_ADD;
      end
      dlipd_pkg::STEP_FIN: begin
        w.wb_en  = 1'b1;
        w.jmp    = dlipd_pkg::JMP_LOOP;
        w.target = dlipd_pkg::STEP_DIFF;
      end
      dlipd_pkg::STEP_SEL: begin
        w.sel_en = 1'b1;
      end
      dlipd_pkg::STEP_MULH: begin
        w.a_sel = dlipd_pkg::MA_HI;
        w.b_sel = dlipd_pkg::MB_PER;
      end
      dlipd_pkg::STEP_MULL: begin
        w.a_sel  = dlipd_pkg::MA_LO;
        w.b_sel  = dlipd_pkg::MB_PER;
        w.acc_op = dlipd_pkg::ACC_PROD;
      end
      dlipd_pkg::STEP_OUT: begin
        w.a_sel  = dlipd_pkg::MA_LO;
        w.b_sel  = dlipd_pkg::MB_PER;
        w.jmp    = dlipd_pkg::JMP_WAIT_OUT;
        w.target = dlipd_pkg::STEP_IDLE;
      end
      default: begin
        w.jmp    = dlipd_pkg::JMP_GOTO;
        w.target = dlipd_pkg::STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  assign uw = ucode(step);

  always_comb begin
    step_next     = step;
    loop_sel_next = loop_sel;
    take          = 1'b0;
    load_out      = 1'b0;
    unique case (uw.jmp)
      dlipd_pkg::JMP_NEXT: begin
        step_next = step + dlipd_pkg::step_t'(1);
      end
      dlipd_pkg::JMP_WAIT_IN: begin
        if (status.in_valid) begin
          take      = 1'b1;
          step_next = step + dlipd_pkg::step_t'(1);
        end
      end
      dlipd_pkg::JMP_LOOP: begin
        if (!loop_sel) begin
          step_next     = uw.target;
          loop_sel_next = 1'b1;
        end else begin
          step_next     = step + dlipd_pkg::step_t'(1);
          loop_sel_next = 1'b0;
        end
      end
      dlipd_pkg::JMP_WAIT_OUT: begin
        if (!status.out_busy) begin
          load_out  = 1'b1;
          step_next = uw.target;
        end
      end
      dlipd_pkg::JMP_GOTO: begin
        step_next = uw.target;
      end
      default: begin
        step_next = dlipd_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= dlipd_pkg::STEP_IDLE;
      loop_sel <= 1'b0;
    end else begin
      step     <= step_next;
      loop_sel <= loop_sel_next;
    end
  end

  assign ctrl.uw       = uw;
  assign ctrl.loop_sel = loop_sel;
  assign ctrl.take     = take;
  assign ctrl.load_out = load_out;
  assign ctrl.in_ready = (uw.jmp == dlipd_pkg::JMP_WAIT_IN);

endmodule

### hw/rtl/dlipd_datapath.sv
// Loop datapath: error terms, shared multiplier, accumulator, clamp and result register.
module dlipd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  dlipd_pkg::cfg_t    regs,
  input  dlipd_pkg::ctrl_t   ctrl,
  dlipd_sample_if.sink       sample,
  dlipd_result_if.source     result,
  output dlipd_pkg::status_t status
);

  dlipd_pkg::sample_t vs;
  dlipd_pkg::sample_t is;
  dlipd_pkg::err_t    err;
  dlipd_pkg::dlt_t    dlt;
  dlipd_pkg::ddl_t    ddl;
  dlipd_pkg::prod_t   prod;
  dlipd_pkg::acc_t    acc;
  dlipd_pkg::err_t    v_err_prev;
  dlipd_pkg::dlt_t    v_dlt_prev;
  dlipd_pkg::duty_t   v_accum;
  dlipd_pkg::err_t    c_err_prev;
  dlipd_pkg::dlt_t    c_dlt_prev;
  dlipd_pkg::duty_t   c_accum;
  dlipd_pkg::duty_t   duty;
  logic               cur_sel;
  logic               out_valid;
  dlipd_pkg::pulse_t  pulse;
  logic               cur_lim;

  dlipd_pkg::sample_t tgt_sel;
  dlipd_pkg::sample_t smp_sel;
  dlipd_pkg::err_t    err_prev_sel;
  dlipd_pkg::dlt_t    dlt_prev_sel;
  dlipd_pkg::duty_t   accum_sel;
  dlipd_pkg::gain_t   kp_sel;
  dlipd_pkg::gain_t   ki_sel;
  dlipd_pkg::gain_t   kd_sel;
  dlipd_pkg::err_t    err_c;
  dlipd_pkg::dlt_t    dlt_c;
  dlipd_pkg::ddl_t    ddl_c;
  dlipd_pkg::gain_t   mul_a;
  dlipd_pkg::ddl_t    mul_b;
  dlipd_pkg::prod_t   prod_c;
  dlipd_pkg::acc_t    fin_sum;
  dlipd_pkg::duty_t   clamped;
  dlipd_pkg::acc_t    out_sum;

  assign tgt_sel      = ctrl.loop_sel ? regs.curr_setpoint : regs.volt_setpoint;
  assign smp_sel      = ctrl.loop_sel ? is : vs;
  assign err_prev_sel = ctrl.loop_sel ? c_err_prev : v_err_prev;
  assign dlt_prev_sel = ctrl.loop_sel ? c_dlt_prev : v_dlt_prev;
  assign accum_sel    = ctrl.loop_sel ? c_accum : v_accum;
  assign kp_sel       = ctrl.loop_sel ? regs.curr_prop_gain : regs.volt_prop_gain;
  assign ki_sel       = ctrl.loop_sel ? regs.curr_integ_gain : regs.volt_integ_gain;
  assign kd_sel       = ctrl.loop_sel ? regs.curr_deriv_gain : regs.volt_deriv_gain;

  assign err_c = dlipd_pkg::err_t'({1'b0, tgt_sel}) - dlipd_pkg::err_t'({1'b0, smp_sel});
  assign dlt_c = dlipd_pkg::dlt_t'(err_c) - dlipd_pkg::dlt_t'(err_prev_sel);
  assign ddl_c = dlipd_pkg::ddl_t'(dlt_c) - dlipd_pkg::ddl_t'(dlt_prev_sel);

  always_comb begin
    case (ctrl.uw.a_sel)
      dlipd_pkg::MA_KP: mul_a = kp_sel;
      dlipd_pkg::MA_KI: mul_a = ki_sel;
      dlipd_pkg::MA_KD: mul_a = kd_sel;
      dlipd_pkg::MA_HI: mul_a = duty[dlipd_pkg::DUTY_FRAC_BITS-1 -: dlipd_pkg::GAIN_W];
      dlipd_pkg::MA_LO: mul_a = dlipd_pkg::gain_t'(duty[dlipd_pkg::LO_W-1:0]);
      default:          mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.uw.b_sel)
      dlipd_pkg::MB_ERR: mul_b = dlipd_pkg::ddl_t'(err);
      dlipd_pkg::MB_DLT: mul_b = dlipd_pkg::ddl_t'(dlt);
      dlipd_pkg::MB_DDL: mul_b = ddl;
      dlipd_pkg::MB_PER: mul_b = dlipd_pkg::PERIOD_OP;
      default:           mul_b = '0;
    endcase
  end

  assign prod_c  = $signed({1'b0, mul_a}) * mul_b;
  assign fin_sum = acc + dlipd_pkg::acc_t'(prod);
  assign out_sum = acc + dlipd_pkg::acc_t'(prod >>> dlipd_pkg::LO_W);

  always_comb begin
    if (fin_sum >= dlipd_pkg::DUTY_ONE) begin
      clamped = dlipd_pkg::DUTY_HIGH;
    end else if (fin_sum <= dlipd_pkg::acc_t'(dlipd_pkg::DUTY_LOW)) begin
      clamped = dlipd_pkg::DUTY_LOW;
    end else begin
      clamped = fin_sum[dlipd_pkg::DUTY_FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      vs <= sample.vout_sample;
      is <= sample.iout_sample;
    end
    if (ctrl.uw.diff_en) begin
      err <= err_c;
      dlt <= dlt_c;
      ddl <= ddl_c;
    end
    prod <= prod_c;
    case (ctrl.uw.acc_op)
      dlipd_pkg::ACC_STATE: acc <= dlipd_pkg::acc_t'(accum_sel);
      dlipd_pkg::ACC_ADD:   acc <= fin_sum;
      dlipd_pkg::ACC_PROD:  acc <= dlipd_pkg::acc_t'(prod);
      default: begin
      end
    endcase
    if (ctrl.uw.sel_en) begin
      cur_sel <= (v_accum >= c_accum);
      duty    <= (v_accum >= c_accum) ? c_accum : v_accum;
    end
    if (ctrl.load_out) begin
      pulse   <= out_sum[dlipd_pkg::GAIN_W +: dlipd_pkg::PULSE_W];
      cur_lim <= cur_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_err_prev <= '0;
      v_dlt_prev <= '0;
      v_accum    <= '0;
      c_err_prev <= '0;
      c_dlt_prev <= '0;
      c_accum    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.uw.wb_en) begin
        if (ctrl.loop_sel) begin
          c_accum    <= clamped;
          c_err_prev <= err;
          c_dlt_prev <= dlt;
        end else begin
          v_accum    <= clamped;
          v_err_prev <= err;
          v_dlt_prev <= dlt;
        end
      end
      if (ctrl.load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sample.ready            = ctrl.in_ready && !rst;
  assign result.valid            = out_valid;
  assign result.compare_value    = pulse;
  assign result.half_pulse       = pulse[dlipd_pkg::PULSE_W-1:1];
  assign result.current_limiting = cur_lim;

  assign status.in_valid = sample.valid && !rst;
  assign status.out_busy = out_valid && !result.ready;

endmodule

### hw/rtl/dual_loop_incremental_pid_duty.sv
// Top level of the dual-loop incremental PID duty controller.
// Each sample item (one voltage and one current reading) runs through a
// voltage and a current incremental PID loop, each keeping a duty fraction
// with 40 fraction bits clamped to [0.02, 1.0); the smaller duty wins (ties
// go to the current loop, flagged by current_limiting) and is scaled to the
// PWM period. A ten-step microprogram drives one shared 25x19 multiplier and
// one 48-bit accumulator: an item occupies the block from acceptance until
// its result is loaded, five steps per loop for the proportional, integral
// and derivative products plus four for the select and period scaling, and
// one idle step takes the next item, so only one item is in flight at a time.
// The next item is taken in the cycle after the result is loaded, even while
// that result still waits at the output; a result is only loaded once the
// previous one has been taken.
// Configuration writes are accepted in every cycle outside reset.
module dual_loop_incremental_pid_duty (
  input  logic           clk,
  input  logic           rst,
  dlipd_sample_if.sink   sample,
  dlipd_result_if.source result,
  dlipd_cfg_if.sink      cfg
);

  dlipd_pkg::cfg_t    regs;
  dlipd_pkg::ctrl_t   ctrl;
  dlipd_pkg::status_t status;

  dlipd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  dlipd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  dlipd_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .ctrl   (ctrl),
    .sample (sample),
    .result (result),
    .status (status)
  );

endmodule

### hw/rtl/dlipd_checker.sv
// Port-level checks for the duty controller, bound to the top level.
module dlipd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input dlipd_pkg::pulse_t             compare_value,
  input logic [dlipd_pkg::PULSE_W-2:0] half_pulse
);

  a_one_item_in_flight: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("input taken again right after an accept");

  a_no_instant_result: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid)
  ) else $error("result appeared the cycle after an accept");

  a_half_pulse: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> (half_pulse == compare_value[dlipd_pkg::PULSE_W-1:1])
  ) else $error("half pulse does not match compare value");

  a_pulse_in_period: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> (compare_value < dlipd_pkg::pulse_t'(dlipd_pkg::PERIOD_COUNTS))
  ) else $error("compare value reaches the period");

  a_result_held: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(compare_value))
  ) else $error("stalled result changed");

endmodule

bind dual_loop_incremental_pid_duty dlipd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (sample.valid),
  .in_ready      (sample.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .compare_value (result.compare_value),
  .half_pulse    (result.half_pulse)
);
